### design/tppr_pkg.sv
// shared types, codes and defaults for the tactile pin pattern ramp unit
`default_nettype none

package tppr_pkg;

  localparam int PINS_X_DEF       = 8;
  localparam int PINS_Y_DEF       = 8;
  localparam int PRESS_LEVELS_DEF = 4;

  localparam int ONE_Q14 = 16384;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 4;
  localparam int STEP_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_EMIT  = 2'd1,
    MODE_OFF   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SLIP  = 2'd0,
    KIND_ROLL  = 2'd1,
    KIND_PRESS = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KIND = 2'd0,
    CFG_ROW  = 2'd1,
    CFG_DIR  = 2'd2,
    CFG_SPARE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    kind_t                    kind;
    logic                     all_rows;
    logic [ROW_W-1:0]         row;
    logic signed [STEP_W-1:0] step;
  } frame_desc_t;

  localparam frame_desc_t ZERO_DESC = '{kind: KIND_NONE, all_rows: 1'b0,
                                        row: '0, step: '0};

  typedef struct packed {
    logic load_step;
    logic ramp_off;
    logic hard_zero;
    logic emit_start;
    logic issue;
  } tppr_cmd_t;

  typedef struct packed {
    logic last_pin;
    logic pipe_busy;
  } tppr_stat_t;

endpackage

`default_nettype wire

### design/tppr_pattern.sv
// pin level of one frame description at a given row and column
`default_nettype none

module tppr_pattern import tppr_pkg::*; #(
  parameter int PINS_X       = PINS_X_DEF,
  parameter int PRESS_LEVELS = PRESS_LEVELS_DEF
) (
  input  frame_desc_t        desc,
  input  logic [ROW_W-1:0]   row,
  input  logic [COL_W-1:0]   col,
  output logic signed [15:0] value
);

  localparam int LW = (PRESS_LEVELS > 0) ? $clog2(PRESS_LEVELS + 1) : 1;
  localparam logic signed [6:0] P_S   = 7'(PRESS_LEVELS);
  localparam logic signed [6:0] LOW_S = 7'(2 * PRESS_LEVELS - 1 - PINS_X);
  localparam logic signed [15:0] POS_ONE = 16'(ONE_Q14);
  localparam logic signed [15:0] NEG_ONE = -16'(ONE_Q14);

  logic [15:0] mag_tab [0:PRESS_LEVELS];

  genvar g;
  generate
    for (g = 0; g <= PRESS_LEVELS; g++) begin : g_mag
      assign mag_tab[g] = 16'((g * ONE_Q14) / PRESS_LEVELS);
    end
  endgenerate

  logic signed [6:0]  col_s;
  logic signed [6:0]  s_s;
  logic signed [6:0]  s1;
  logic signed [6:0]  f;
  logic signed [6:0]  lv;
  logic signed [6:0]  abs_l;
  logic               hit;
  logic               neg;
  logic               flip;
  logic signed [15:0] m;
  logic signed [15:0] press_v;
  logic               in_row;

  assign col_s  = $signed({3'b000, col});
  assign s_s    = $signed({desc.step[STEP_W-1], desc.step});
  assign s1     = s_s + 7'sd1;
  assign in_row = desc.all_rows || (desc.row == row);

  always_comb begin
    f   = '0;
    hit = 1'b0;
    neg = 1'b0;
    if (col_s >= P_S) begin
      f   = col_s - P_S;
      hit = 1'b1;
    end else if (col_s > LOW_S) begin
      f   = P_S - 7'sd1 - col_s;
      hit = 1'b1;
      neg = 1'b1;
    end
    lv = f + 7'sd1;
    if (s1 < lv) lv = s1;
    if (lv > P_S) lv = P_S;
    if (lv < -P_S) lv = -P_S;
    abs_l = (lv < 0) ? -lv : lv;
    flip  = (lv < 0) ^ neg;
    m     = $signed(mag_tab[abs_l[LW-1:0]]);
    press_v = hit ? (flip ? -m : m) : 16'sd0;
  end

  always_comb begin
    value = '0;
    if (in_row) begin
      unique case (desc.kind)
        KIND_SLIP:  value = (col_s <= s_s) ? NEG_ONE : POS_ONE;
        KIND_ROLL: begin
          if (col_s < s1) value = NEG_ONE;
          else if (col_s > s1) value = POS_ONE;
          else value = '0;
        end
        KIND_PRESS: value = press_v;
        KIND_NONE:  value = '0;
        default:    value = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/tppr_ctrl.sv
// command decode and pin walk controller
`default_nettype none

module tppr_ctrl import tppr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  tppr_stat_t stat,
  output tppr_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  mode_t  mode;

  assign mode   = mode_t'(in_mode);
  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load_step  = accept && (mode == MODE_LOAD);
    cmd.ramp_off   = accept && (mode == MODE_OFF);
    cmd.hard_zero  = accept && (mode == MODE_CLEAR);
    cmd.emit_start = accept && ((mode == MODE_EMIT) || (mode == MODE_CLEAR));
    cmd.issue      = (state_r == ST_WALK);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (cmd.emit_start) state_nxt = ST_WALK;
      ST_WALK:  if (stat.last_pin) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!stat.pipe_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/tppr_datapath.sv
// config registers, frame descriptions, pin counters and interpolation pipeline
`default_nettype none

module tppr_datapath import tppr_pkg::*; #(
  parameter int PINS_X       = PINS_X_DEF,
  parameter int PINS_Y       = PINS_Y_DEF,
  parameter int PRESS_LEVELS = PRESS_LEVELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tppr_cmd_t             cmd,
  output tppr_stat_t            stat,
  input  logic [2:0]            in_step_index,
  input  logic [16:0]           in_fraction,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [5:0]            out_pin_index,
  output logic signed [15:0]    out_pin_value,
  output logic                  out_frame_end
);

  localparam int NPINS = PINS_X * PINS_Y;
  localparam int PW = $clog2(NPINS);
  localparam int RW = (PINS_Y > 1) ? $clog2(PINS_Y) : 1;
  localparam int CW = $clog2(PINS_X);

  kind_t       kind_r;
  logic [3:0]  row_sel_r;
  logic        dir_r;
  frame_desc_t tgt_r, prev_r, new_desc;
  logic [16:0] frac_r;

  logic [PW-1:0] pin_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;

  logic signed [15:0] tgt_v, prev_v;

  logic               v1_r, v2_r, out_valid_r;
  logic               last1_r, last2_r, last3_r;
  logic [PW-1:0]      idx1_r, idx2_r, idx3_r;
  logic signed [16:0] d1_r;
  logic signed [15:0] prev1_r, prev2_r, val3_r;
  logic signed [34:0] prod_r;
  logic signed [18:0] sum;
  logic [STEP_W-1:0]  step_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= KIND_NONE;
      row_sel_r <= '0;
      dir_r     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KIND:  kind_r    <= kind_t'(cfg_data[1:0]);
        CFG_ROW:   row_sel_r <= cfg_data;
        CFG_DIR:   dir_r     <= cfg_data[0];
        CFG_SPARE: ;
        default:   ;
      endcase
    end
  end

  // new target description from the registers and the step
  assign step_ext = {3'b000, in_step_index};

  always_comb begin
    new_desc          = ZERO_DESC;
    new_desc.kind     = kind_r;
    new_desc.all_rows = row_sel_r[3];
    if ({2'b00, row_sel_r[2:0]} > 5'(PINS_Y - 1)) new_desc.row = ROW_W'(PINS_Y - 1);
    else new_desc.row = {1'b0, row_sel_r[2:0]};
    new_desc.step = dir_r ? $signed(STEP_W'(PINS_X - 2) - step_ext) : $signed(step_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= ZERO_DESC;
      prev_r <= ZERO_DESC;
    end else begin
      if (cmd.load_step) begin
        prev_r <= tgt_r;
        tgt_r  <= new_desc;
      end else if (cmd.ramp_off) begin
        prev_r <= tgt_r;
        tgt_r  <= ZERO_DESC;
      end else if (cmd.hard_zero) begin
        prev_r <= ZERO_DESC;
        tgt_r  <= ZERO_DESC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      frac_r <= (in_fraction[16] && (|in_fraction[15:0])) ? 17'h10000 : in_fraction;
    end
  end

  // pin walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.emit_start) begin
      pin_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.issue) begin
      pin_r <= pin_r + PW'(1);
      if (col_r == CW'(PINS_X - 1)) begin
        col_r <= '0;
        row_r <= row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  tppr_pattern #(.PINS_X(PINS_X), .PRESS_LEVELS(PRESS_LEVELS)) u_tgt (
    .desc  (tgt_r),
    .row   (ROW_W'(row_r)),
    .col   (COL_W'(col_r)),
    .value (tgt_v)
  );

  tppr_pattern #(.PINS_X(PINS_X), .PRESS_LEVELS(PRESS_LEVELS)) u_prev (
    .desc  (prev_r),
    .row   (ROW_W'(row_r)),
    .col   (COL_W'(col_r)),
    .value (prev_v)
  );

  assign stat.last_pin  = (pin_r == PW'(NPINS - 1));
  assign stat.pipe_busy = v1_r || v2_r;

  // difference, product, sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      last1_r     <= 1'b0;
      last2_r     <= 1'b0;
      last3_r     <= 1'b0;
    end else begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
      last1_r     <= cmd.issue && stat.last_pin;
      last2_r     <= v1_r && last1_r;
      last3_r     <= v2_r && last2_r;
    end
  end

  assign sum = {{3{prev2_r[15]}}, prev2_r} + prod_r[34:16];

  always_ff @(posedge clk) begin
    d1_r    <= {tgt_v[15], tgt_v} - {prev_v[15], prev_v};
    prev1_r <= prev_v;
    idx1_r  <= pin_r;
    prod_r  <= d1_r * $signed({1'b0, frac_r});
    prev2_r <= prev1_r;
    idx2_r  <= idx1_r;
    val3_r  <= sum[15:0];
    idx3_r  <= idx2_r;
  end

  assign out_valid     = out_valid_r;
  assign out_pin_index = 6'(idx3_r);
  assign out_pin_value = val3_r;
  assign out_frame_end = last3_r;

endmodule

`default_nettype wire

### design/tactile_pin_pattern_ramp_unit.sv
// top level of the tactile pin pattern ramp unit
//
// Commands enter on start/in_mode/in_step_index/in_fraction and are taken at a
// clock edge where start is high and busy is low. Load step and target to zero
// complete in the accept cycle and emit nothing; busy stays low. Emit frame and
// hard zero walk all PINS_X*PINS_Y pins, one pin per cycle, and produce one
// result transaction per pin on out_pin_index/out_pin_value/out_frame_end,
// each marked by out_valid for one cycle, out_frame_end on the last pin.
// Each result passes through the pin walk counter and the three stage
// difference/multiply/add pipeline, and a frame command keeps busy high
// until its last result is on the ports. The receiver cannot stall.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken
// (cfg_ready is high) and must be made while busy is low.
// Reset clears both frames to zero, the pattern kind to none, the row select to
// row 0 and the direction to right; no clearing pass is needed.
`default_nettype none

module tactile_pin_pattern_ramp_unit import tppr_pkg::*; #(
  parameter int PINS_X       = PINS_X_DEF,
  parameter int PINS_Y       = PINS_Y_DEF,
  parameter int PRESS_LEVELS = PRESS_LEVELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_mode,
  input  logic [2:0]            in_step_index,
  input  logic [16:0]           in_fraction,
  output logic                  out_valid,
  output logic [5:0]            out_pin_index,
  output logic signed [15:0]    out_pin_value,
  output logic                  out_frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NPINS = PINS_X * PINS_Y;

  tppr_cmd_t  cmd;
  tppr_stat_t stat;

  assign cfg_ready = 1'b1;

  tppr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  tppr_datapath #(
    .PINS_X       (PINS_X),
    .PINS_Y       (PINS_Y),
    .PRESS_LEVELS (PRESS_LEVELS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_step_index (in_step_index),
    .in_fraction   (in_fraction),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_pin_index (out_pin_index),
    .out_pin_value (out_pin_value),
    .out_frame_end (out_frame_end)
  );

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result transaction outside a frame command");

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_frame_end |-> (out_valid && (out_pin_index == 6'(NPINS - 1))))
    else $error("frame end not on the last pin");

  a_frame_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_EMIT || in_mode == MODE_CLEAR)) |=> busy)
    else $error("frame command did not raise busy");

  a_silent_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_LOAD || in_mode == MODE_OFF)) |=> !busy)
    else $error("silent command raised busy");

endmodule

`default_nettype wire
